// ----- rtl/fvct_pkg.sv -----
// Package for the four-voice chip tune mixer: wave codes, commands, constants.
// No dependencies; used by fvct_phase and the top level.
package fvct_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_VOICE  = 2'd1,
    CMD_EFFECT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    WAVE_PULSE50  = 2'd0,
    WAVE_PULSE25  = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_NOISE    = 2'd3
  } wave_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PHASE,
    ST_SCALE,
    ST_WEIGHT,
    ST_CLIP,
    ST_OUT
  } state_t;

  // Byte address of the effect volume register.
  localparam logic [1:0]  REG_EFFECT_VOLUME = 2'd0;

  localparam logic [7:0]  EFFECT_VOLUME_RESET = 8'd220;
  localparam int          PHASE_W = 32;
  localparam int          DIGIT_W = 4;
  localparam int          DIGITS  = PHASE_W / DIGIT_W;

  // Reset values of the voice levels and the noise registers.
  function automatic logic [7:0] level_reset(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = 8'd200;
      2'd1: r = 8'd190;
      2'd2: r = 8'd180;
      default: r = 8'd170;
    endcase
    return r;
  endfunction

  function automatic logic [14:0] noise_reset(input logic [1:0] idx);
    logic [14:0] r;
    unique case (idx)
      2'd0: r = 15'h1ACE;
      2'd1: r = 15'h2B5D;
      2'd2: r = 15'h35E7;
      default: r = 15'h3F2D;
    endcase
    return r;
  endfunction

  // One LFSR step, with the all-zero state replaced by one.
  function automatic logic [14:0] lfsr_step(input logic [14:0] r);
    logic [14:0] n;
    n = {r[0] ^ r[1], r[14:1]};
    if (n == 15'd0) n = 15'd1;
    return n;
  endfunction

  // Raw sample of a wave from the new phase's top bits and the noise bit.
  function automatic logic signed [7:0] tone_level(input logic [1:0] kind,
                                                   input logic [4:0] top,
                                                   input logic noise_bit);
    logic signed [7:0] s;
    unique case (kind)
      WAVE_PULSE50:  s = top[4] ? 8'sd110 : -8'sd110;
      WAVE_PULSE25:  s = (top[4:3] == 2'b00) ? 8'sd96 : -8'sd96;
      WAVE_TRIANGLE: s = top[4] ? 8'(8'sd120 - 8'(signed'({4'd0, top[3:0]}) <<< 4))
                                : 8'(8'(signed'({4'd0, top[3:0]}) <<< 4) - 8'sd120);
      default:       s = noise_bit ? 8'sd90 : -8'sd90;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/fvct_phase.sv -----
// Digit-serial phase accumulator: adds a 32-bit step to a phase four bits per cycle.
// Depends on fvct_pkg.
module fvct_phase (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] phase,
  input  logic [31:0] step,
  output logic        done,
  output logic [31:0] sum,
  output logic        wrap
);

  localparam int CNT_W = $clog2(fvct_pkg::DIGITS + 1);

  logic [31:0]      a_sr;
  logic [31:0]      b_sr;
  logic             carry;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic [fvct_pkg::DIGIT_W:0] dsum;

  assign dsum = {1'b0, a_sr[fvct_pkg::DIGIT_W-1:0]}
              + {1'b0, b_sr[fvct_pkg::DIGIT_W-1:0]} + {{fvct_pkg::DIGIT_W{1'b0}}, carry};

  // Shift both operands right one digit per cycle; the sum enters at the top of a_sr.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        carry <= 1'b0;
        a_sr  <= phase;
        b_sr  <= step;
      end else if (busy) begin
        a_sr  <= {dsum[fvct_pkg::DIGIT_W-1:0], a_sr[31:fvct_pkg::DIGIT_W]};
        b_sr  <= b_sr >> fvct_pkg::DIGIT_W;
        carry <= dsum[fvct_pkg::DIGIT_W];
        count <= count + CNT_W'(1);
        if (count == CNT_W'(fvct_pkg::DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sum  = a_sr;
  assign wrap = carry;

endmodule

// ----- rtl/fvct_mult.sv -----
// Shift-and-add multiplier: signed 12-bit value times unsigned 10-bit factor, one bit a cycle.
// Does not use fvct_pkg; used for volume, weight and clip scaling.
module fvct_mult (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [11:0] a,
  input  logic [9:0]         b,
  output logic               done,
  output logic signed [21:0] prod
);

  logic [9:0]         b_sr;
  logic signed [21:0] a_sh;
  logic signed [21:0] acc;
  logic [3:0]         count;
  logic               busy;

  // One multiplier bit per cycle, least significant first.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        acc   <= '0;
        a_sh  <= 22'(a);
        b_sr  <= b;
      end else if (busy) begin
        if (b_sr[0]) acc <= acc + a_sh;
        a_sh  <= a_sh <<< 1;
        b_sr  <= b_sr >> 1;
        count <= count + 4'd1;
        if (count == 4'd9) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;

endmodule

// ----- rtl/four_voice_chip_tune_mixer.sv -----
// Four-voice chip tune mixer top level: command decode, voice state, sequencer, output register.
// Depends on fvct_pkg, fvct_phase and fvct_mult.
//
// A write command (voice or effect) is taken whenever the sequencer is idle. A
// sample tick walks the music voices and then the effect voice one after
// another. An idle voice is passed over; an active one takes a start step, a
// digit-serial phase add and a serial multiply by its volume, and a music voice
// on any wave but the 50% pulse takes a second multiply by its weight. The soft
// clip takes one more multiply step. A tick lasts longest with all five voices
// on; the serial adder and the single shared shift-and-add multiplier set its
// length. The result sits in an output register, and a new item is taken while
// it waits; a following tick holds before its soft clip until that register is
// free.
module four_voice_chip_tune_mixer #(
  parameter int NUM_VOICES = 4
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: command[1:0], voice_index[3:2], wave_kind[5:4], phase_increment[37:6],
  //          voice_volume[45:38], zero fill [47:46]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: dac_code[7:0]
  output logic [7:0]  m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int VI_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int SEL_W = $clog2(NUM_VOICES + 2);

  // Voice state; sel value NUM_VOICES stands for the effect voice, held in its own registers.
  logic [31:0] voice_phase [NUM_VOICES];
  logic [31:0] voice_step  [NUM_VOICES];
  logic [1:0]  voice_wave  [NUM_VOICES];
  logic [7:0]  voice_level [NUM_VOICES];
  logic        voice_enabled [NUM_VOICES];
  logic [14:0] noise_register [NUM_VOICES];
  logic [31:0] effect_phase;
  logic [31:0] effect_step;
  logic [1:0]  effect_wave;
  logic [7:0]  effect_volume;

  fvct_pkg::state_t state, state_next;
  logic [SEL_W-1:0] sel;
  logic             lead;
  logic signed [10:0] mix;
  logic signed [11:0] samp;
  logic [7:0]  out_code;
  logic        out_valid;

  // Input decode.
  logic [1:0]  in_cmd, in_vi, in_wk;
  logic [31:0] in_inc;
  logic [7:0]  in_vol;
  logic        in_xfer;
  assign in_cmd = s_tdata[1:0];
  assign in_vi  = s_tdata[3:2];
  assign in_wk  = s_tdata[5:4];
  assign in_inc = s_tdata[37:6];
  assign in_vol = s_tdata[45:38];
  assign s_tready = (state == fvct_pkg::ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;

  // Current voice view.
  logic        is_eff;
  logic [VI_W-1:0] vi;
  logic        cur_active;
  logic [31:0] cur_phase, cur_step;
  logic [1:0]  cur_wave;
  logic [7:0]  cur_vol;
  assign is_eff = (sel == SEL_W'(NUM_VOICES));
  assign vi = is_eff ? '0 : VI_W'(sel);
  assign cur_phase = is_eff ? effect_phase : voice_phase[vi];
  assign cur_step  = is_eff ? effect_step : voice_step[vi];
  assign cur_wave  = is_eff ? effect_wave : voice_wave[vi];
  assign cur_vol   = is_eff ? effect_volume : voice_level[vi];
  assign cur_active = is_eff ? (effect_step != 32'd0)
                             : (voice_enabled[vi] && voice_step[vi] != 32'd0);

  // Serial units.
  logic        ph_start, ph_done, ph_wrap;
  logic [31:0] ph_sum;
  fvct_phase u_phase (
    .clk(clk), .rst(rst), .start(ph_start), .phase(cur_phase), .step(cur_step),
    .done(ph_done), .sum(ph_sum), .wrap(ph_wrap)
  );

  logic               mu_start, mu_done;
  logic signed [11:0] mu_a;
  logic [9:0]         mu_b;
  logic signed [21:0] mu_prod;
  fvct_mult u_mult (
    .clk(clk), .rst(rst), .start(mu_start), .a(mu_a), .b(mu_b),
    .done(mu_done), .prod(mu_prod)
  );

  // Division by 255 with truncation toward zero on a magnitude below 2^15.
  logic        neg;
  logic [20:0] mag;
  logic [20:0] q255;
  logic [20:0] q_tmp;
  logic signed [11:0] div255;
  assign neg   = mu_prod[21];
  assign mag   = neg ? 21'(-mu_prod) : mu_prod[20:0];
  assign q_tmp = 21'((mag + (mag >> 8) + 21'd1) >> 8);
  assign q255  = q_tmp;
  assign div255 = neg ? -12'(q255) : 12'(q255);

  logic signed [11:0] div256, div512;
  assign div256 = neg ? -12'(mag >> 8) : 12'(mag >> 8);
  assign div512 = neg ? -12'(mag >> 9) : 12'(mag >> 9);

  logic [7:0] weight;
  always_comb begin
    unique case (cur_wave)
      fvct_pkg::WAVE_PULSE50:  weight = 8'd0;
      fvct_pkg::WAVE_PULSE25:  weight = 8'd192;
      fvct_pkg::WAVE_TRIANGLE: weight = 8'd176;
      default:                 weight = lead ? 8'd104 : 8'd140;
    endcase
  end

  logic signed [9:0] mix_cl;
  logic [8:0]        mix_abs;
  assign mix_cl  = (mix > 11'sd384) ? 10'sd384 : ((mix < -11'sd384) ? -10'sd384 : 10'(mix));
  assign mix_abs = mix_cl[9] ? 9'(-mix_cl) : 9'(mix_cl);

  logic signed [11:0] clipped;
  assign clipped = (div512 > 12'sd127) ? 12'sd127 : ((div512 < -12'sd127) ? -12'sd127 : div512);

  logic [14:0] cur_noise, new_noise;
  assign cur_noise = noise_register[vi];
  assign new_noise = ph_wrap ? fvct_pkg::lfsr_step(cur_noise) : cur_noise;

  // Raw sample of the current voice, valid while the phase add reports done.
  assign samp = 12'(fvct_pkg::tone_level(cur_wave, ph_sum[31:27], new_noise[0]));

  // Sequencer next state and unit starts.
  always_comb begin
    state_next = state;
    ph_start = 1'b0;
    mu_start = 1'b0;
    mu_a = samp;
    mu_b = {2'b00, cur_vol};
    unique case (state)
      fvct_pkg::ST_IDLE: begin
        if (in_xfer && in_cmd == fvct_pkg::CMD_TICK) state_next = fvct_pkg::ST_PHASE;
      end
      fvct_pkg::ST_PHASE: begin
        if (sel > SEL_W'(NUM_VOICES)) begin
          // The soft clip starts only once the output register is free.
          if (!out_valid || m_tready) begin
            state_next = fvct_pkg::ST_CLIP;
            mu_start = 1'b1;
            mu_a = 12'(mix_cl);
            mu_b = 10'(10'd512 - 10'(mix_abs));
          end
        end else if (ph_done) begin
          state_next = fvct_pkg::ST_SCALE;
        end else if (!cur_active) begin
          state_next = fvct_pkg::ST_PHASE;
        end else begin
          ph_start = 1'b1;
          state_next = fvct_pkg::ST_WEIGHT;
        end
      end
      fvct_pkg::ST_WEIGHT: begin
        // The volume multiply starts as soon as the phase add is done.
        if (ph_done) begin
          mu_start = 1'b1;
          state_next = fvct_pkg::ST_SCALE;
        end
      end
      fvct_pkg::ST_SCALE: begin
        if (mu_done) begin
          state_next = (is_eff || cur_wave == fvct_pkg::WAVE_PULSE50)
                       ? fvct_pkg::ST_PHASE : fvct_pkg::ST_OUT;
          if (!(is_eff || cur_wave == fvct_pkg::WAVE_PULSE50)) begin
            mu_start = 1'b1;
            mu_a = div255;
            mu_b = {2'b00, weight};
          end
        end
      end
      fvct_pkg::ST_OUT: begin
        if (mu_done) state_next = fvct_pkg::ST_PHASE;
      end
      fvct_pkg::ST_CLIP: begin
        if (mu_done) state_next = fvct_pkg::ST_IDLE;
      end
      default: state_next = fvct_pkg::ST_IDLE;
    endcase
  end

  // Sequencer registers, voice state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fvct_pkg::ST_IDLE;
      out_valid <= 1'b0;
      sel <= '0;
      for (int i = 0; i < NUM_VOICES; i++) begin
        voice_phase[i] <= '0;
        voice_step[i] <= '0;
        voice_wave[i] <= '0;
        voice_level[i] <= fvct_pkg::level_reset(2'(i));
        voice_enabled[i] <= 1'b0;
        noise_register[i] <= fvct_pkg::noise_reset(2'(i));
      end
      effect_phase <= '0;
      effect_step <= '0;
      effect_wave <= '0;
      effect_volume <= fvct_pkg::EFFECT_VOLUME_RESET;
    end else begin
      state <= state_next;
      if (out_valid && m_tready) out_valid <= 1'b0;
      if (psel && penable && pwrite && paddr == fvct_pkg::REG_EFFECT_VOLUME)
        effect_volume <= pwdata[7:0];

      unique case (state)
        fvct_pkg::ST_IDLE: begin
          if (in_xfer) begin
            if (in_cmd == fvct_pkg::CMD_VOICE && {30'd0, in_vi} < NUM_VOICES) begin
              if (in_inc == 32'd0) begin
                voice_enabled[VI_W'(in_vi)] <= 1'b0;
                voice_step[VI_W'(in_vi)] <= '0;
              end else begin
                voice_wave[VI_W'(in_vi)] <= in_wk;
                voice_level[VI_W'(in_vi)] <= in_vol;
                voice_step[VI_W'(in_vi)] <= in_inc;
                voice_enabled[VI_W'(in_vi)] <= 1'b1;
              end
            end else if (in_cmd == fvct_pkg::CMD_EFFECT) begin
              effect_wave <= in_wk;
              effect_phase <= '0;
              effect_step <= in_inc;
            end
            sel <= '0;
            mix <= '0;
            lead <= 1'b0;
            for (int i = 0; i < NUM_VOICES; i++)
              if (voice_enabled[i] && voice_step[i] != 32'd0 &&
                  voice_wave[i] == fvct_pkg::WAVE_PULSE50)
                lead <= 1'b1;
          end
        end
        fvct_pkg::ST_PHASE: begin
          if (sel <= SEL_W'(NUM_VOICES) && !cur_active) sel <= sel + SEL_W'(1);
        end
        fvct_pkg::ST_WEIGHT: begin
          if (ph_done) begin
            if (is_eff) effect_phase <= ph_sum;
            else voice_phase[vi] <= ph_sum;
            if (cur_wave == fvct_pkg::WAVE_NOISE) noise_register[vi] <= new_noise;
          end
        end
        fvct_pkg::ST_SCALE: begin
          if (mu_done && (is_eff || cur_wave == fvct_pkg::WAVE_PULSE50)) begin
            mix <= 11'(mix + 11'(div255));
            sel <= sel + SEL_W'(1);
          end
        end
        fvct_pkg::ST_OUT: begin
          if (mu_done) begin
            mix <= 11'(mix + 11'(div256));
            sel <= sel + SEL_W'(1);
          end
        end
        fvct_pkg::ST_CLIP: begin
          if (mu_done) begin
            out_code  <= 8'(clipped + 12'sd128);
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_code;
  assign prdata   = {24'd0, (paddr == fvct_pkg::REG_EFFECT_VOLUME) ? effect_volume : 8'd0};
  assign pready   = 1'b1;

endmodule

// ----- rtl/fvct_checker.sv -----
// Port-level checker for the four-voice chip tune mixer, bound to the top level.
// Depends only on the top level's ports.
module fvct_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        pready
);

  // A waiting result keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // A waiting result stays offered until its transfer.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // The DAC code never reaches zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata != 8'd0)
    else $error("dac code out of range");

  // No result right after reset.
  assert property (@(posedge clk) $fell(rst) |-> !m_tvalid)
    else $error("result during reset");

  // The configuration port never waits.
  assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind four_voice_chip_tune_mixer fvct_checker u_fvct_checker (
  .clk(clk), .rst(rst),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);
